// File: rtl/delta_list_sleep_timer_queue_assert.svh
// assertion macros used by the timer queue checker
`ifndef DELTA_LIST_SLEEP_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_SLEEP_TIMER_QUEUE_ASSERT_SVH

// consequent checked in the same cycle
`define DLQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dlq_pkg.sv
// types and constants for the delta-list timer queue
package dlq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_W          = 8;
    localparam int DUR_W           = 32;
    localparam int DELTA_W         = 33;
    localparam int DIFF_W          = DELTA_W + 1;
    localparam int TICK_W          = 20;
    localparam int REM_W           = 32;

    localparam logic [TICK_W-1:0] TICK_RESET = 20'd10000;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [2:0] KIND_INSERTED  = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_EXPIRED   = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TASK_W-1:0] task_id;
        logic [DUR_W-1:0]  duration_us;
    } req_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TASK_W-1:0] task_id_out;
        logic [REM_W-1:0]  remaining_us;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic [TASK_W-1:0]         tid;
        logic signed [DELTA_W-1:0] delta;
    } entry_t;

endpackage

// File: rtl/delta_list_sleep_timer_queue.sv
// delta-list timer queue top level: ring-addressed entry memory and command sequencer
// insert: walk to the slot, shift the tail up where entries follow it, write; cancel: walk, then close the gap
// tick: the head is checked, then each expired entry in turn; paced by the single read port of the entry memory
// one command in flight; the next is taken while the last result waits in the output register
// reset clears the entry count, ring base and output valid, tick length returns to 10000
// entry memory is not cleared; no clearing pass after reset
module delta_list_sleep_timer_queue #(
    parameter int QUEUE_DEPTH = dlq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  dlq_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output dlq_pkg::rsp_t              rsp,
    input  logic                       tick_length_we,
    input  logic [dlq_pkg::TICK_W-1:0] tick_length_us
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = dlq_pkg::DELTA_W + IDX_W + 1;
    localparam int DIFF_W = dlq_pkg::DIFF_W;
    localparam int DELTA_W = dlq_pkg::DELTA_W;
    localparam int TASK_W = dlq_pkg::TASK_W;
    localparam int REM_W = dlq_pkg::REM_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_WALK  = 4'd1;
    localparam logic [3:0] S_INS_SHIFT = 4'd2;
    localparam logic [3:0] S_INS_PUT   = 4'd3;
    localparam logic [3:0] S_CAN_WALK  = 4'd4;
    localparam logic [3:0] S_CAN_SHIFT = 4'd5;
    localparam logic [3:0] S_TICK_HEAD = 4'd6;
    localparam logic [3:0] S_TICK_NEXT = 4'd7;
    localparam logic [3:0] S_RESP      = 4'd8;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                               input logic [CNT_W-1:0] i);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, b} + {1'b0, i};
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [REM_W-1:0] clamp_rem(input logic signed [SUM_W-1:0] s);
        if (s[SUM_W-1])
        begin
            return '0;
        end
        else if (|s[SUM_W-2:REM_W])
        begin
            return '1;
        end
        else
        begin
            return s[REM_W-1:0];
        end
    endfunction

    logic [3:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                 base_reg, base_next;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic [CNT_W-1:0]                 pos_reg, pos_next;
    logic [TASK_W-1:0]                task_reg, task_next;
    logic signed [DIFF_W-1:0]         dur_reg, dur_next;
    logic signed [SUM_W-1:0]          sum_reg, sum_next;
    logic signed [DELTA_W-1:0]        hit_delta_reg, hit_delta_next;
    logic [TASK_W-1:0]                pend_task_reg, pend_task_next;
    logic [2:0]                       res_kind_reg, res_kind_next;
    logic [TASK_W-1:0]                res_task_reg, res_task_next;
    logic [REM_W-1:0]                 res_rem_reg, res_rem_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    dlq_pkg::rsp_t                    rsp_reg, rsp_next;
    logic [dlq_pkg::TICK_W-1:0]       tick_length_reg;

    dlq_pkg::entry_t                  mem [QUEUE_DEPTH];
    dlq_pkg::entry_t                  rd_entry_reg;
    logic                             rd_en;
    logic [CNT_W-1:0]                 rd_idx;
    logic                             wr_en;
    logic [CNT_W-1:0]                 wr_idx;
    dlq_pkg::entry_t                  wr_entry;
    logic [IDX_W-1:0]                 rd_addr;
    logic [IDX_W-1:0]                 wr_addr;

    logic                             out_free;
    logic signed [DIFF_W-1:0]         delta_ext;
    logic signed [DIFF_W-1:0]         tick_ext;
    logic signed [DIFF_W-1:0]         diff;
    logic signed [DIFF_W-1:0]         succ_delta;
    logic signed [DIFF_W-1:0]         head_left;
    logic signed [SUM_W-1:0]          sum_add;
    logic                             head_expired;
    logic [CNT_W-1:0]                 idx_inc;
    logic [CNT_W-1:0]                 idx_dec;
    logic [CNT_W-1:0]                 pos_inc;
    logic [CNT_W-1:0]                 count_dec;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign rd_addr = phys(base_reg, rd_idx);
    assign wr_addr = phys(base_reg, wr_idx);

    assign delta_ext    = $signed({rd_entry_reg.delta[DELTA_W-1], rd_entry_reg.delta});
    assign tick_ext     = $signed({{(DIFF_W - dlq_pkg::TICK_W){1'b0}}, tick_length_reg});
    assign diff         = dur_reg - delta_ext;
    assign succ_delta   = delta_ext - dur_reg;
    assign head_left    = delta_ext - tick_ext;
    assign sum_add      = sum_reg + $signed({{(SUM_W - DELTA_W){rd_entry_reg.delta[DELTA_W-1]}},
                                             rd_entry_reg.delta});
    assign head_expired = rd_entry_reg.delta[DELTA_W-1] || (rd_entry_reg.delta == '0);
    assign idx_inc      = idx_reg + CNT_W'(1);
    assign idx_dec      = idx_reg - CNT_W'(1);
    assign pos_inc      = pos_reg + CNT_W'(1);
    assign count_dec    = count_reg - CNT_W'(1);

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        task_next      = task_reg;
        dur_next       = dur_reg;
        sum_next       = sum_reg;
        hit_delta_next = hit_delta_reg;
        pend_task_next = pend_task_reg;
        res_kind_next  = res_kind_reg;
        res_task_next  = res_task_reg;
        res_rem_next   = res_rem_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_idx         = '0;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_entry       = rd_entry_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    task_next = req.task_id;
                    dur_next  = $signed({{(DIFF_W - dlq_pkg::DUR_W){1'b0}}, req.duration_us});
                    idx_next  = '0;
                    sum_next  = '0;
                    rd_en     = 1'b1;
                    rd_idx    = '0;
                    case (req.cmd)
                        dlq_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_kind_next = dlq_pkg::KIND_FULL;
                                res_task_next = req.task_id;
                                res_rem_next  = '0;
                                state_next    = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                state_next = S_INS_WALK;
                            end
                        end
                        dlq_pkg::CMD_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_TICK_HEAD;
                            end
                        end
                        dlq_pkg::CMD_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_kind_next = dlq_pkg::KIND_NOT_FOUND;
                                res_task_next = req.task_id;
                                res_rem_next  = '0;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                state_next = S_CAN_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_WALK:
            begin
                if (diff[DIFF_W-1] || (diff == '0))
                begin
                    pos_next   = idx_reg;
                    rd_en      = 1'b1;
                    rd_idx     = count_dec;
                    idx_next   = count_dec;
                    state_next = S_INS_SHIFT;
                end
                else
                begin
                    dur_next = diff;
                    if (idx_inc == count_reg)
                    begin
                        pos_next   = count_reg;
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_idx   = idx_inc;
                    end
                end
            end

            // move the tail up by one, from the end toward the slot
            S_INS_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_idx = idx_inc;
                if (idx_reg == pos_reg)
                begin
                    wr_entry.delta = $signed(succ_delta[DELTA_W-1:0]);
                    state_next     = S_INS_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_dec;
                    idx_next = idx_dec;
                end
            end

            S_INS_PUT:
            begin
                wr_en          = 1'b1;
                wr_idx         = pos_reg;
                wr_entry.tid   = task_reg;
                wr_entry.delta = $signed(dur_reg[DELTA_W-1:0]);
                count_next     = count_reg + CNT_W'(1);
                res_kind_next  = dlq_pkg::KIND_INSERTED;
                res_task_next  = task_reg;
                res_rem_next   = '0;
                state_next     = S_RESP;
            end

            S_CAN_WALK:
            begin
                sum_next = sum_add;
                if (rd_entry_reg.tid == task_reg)
                begin
                    pos_next       = idx_reg;
                    hit_delta_next = rd_entry_reg.delta;
                    res_kind_next  = dlq_pkg::KIND_CANCELLED;
                    res_task_next  = task_reg;
                    res_rem_next   = clamp_rem(sum_add);
                    if (idx_inc == count_reg)
                    begin
                        count_next = count_dec;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = idx_inc;
                        idx_next   = idx_inc;
                        state_next = S_CAN_SHIFT;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    res_kind_next = dlq_pkg::KIND_NOT_FOUND;
                    res_task_next = task_reg;
                    res_rem_next  = '0;
                    state_next    = S_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                    idx_next = idx_inc;
                end
            end

            // close the gap, successor takes over the removed delta
            S_CAN_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_idx = idx_dec;
                if (idx_reg == pos_inc)
                begin
                    wr_entry.delta = rd_entry_reg.delta + hit_delta_reg;
                end
                if (idx_inc == count_reg)
                begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                    idx_next = idx_inc;
                end
            end

            S_TICK_HEAD:
            begin
                if (head_left[DIFF_W-1] || (head_left == '0))
                begin
                    pend_task_next = rd_entry_reg.tid;
                    base_next      = phys(base_reg, CNT_W'(1));
                    count_next     = count_dec;
                    if (count_reg == CNT_W'(1))
                    begin
                        res_kind_next = dlq_pkg::KIND_EXPIRED;
                        res_task_next = rd_entry_reg.tid;
                        res_rem_next  = '0;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = CNT_W'(1);
                        state_next = S_TICK_NEXT;
                    end
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_idx         = '0;
                    wr_entry.delta = $signed(head_left[DELTA_W-1:0]);
                    state_next     = S_IDLE;
                end
            end

            // previous expiry is sent once the new head shows whether more follow
            S_TICK_NEXT:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.kind         = dlq_pkg::KIND_EXPIRED;
                    rsp_next.task_id_out  = pend_task_reg;
                    rsp_next.remaining_us = '0;
                    rsp_next.last         = !head_expired;
                    if (head_expired)
                    begin
                        pend_task_next = rd_entry_reg.tid;
                        base_next      = phys(base_reg, CNT_W'(1));
                        count_next     = count_dec;
                        if (count_reg == CNT_W'(1))
                        begin
                            res_kind_next = dlq_pkg::KIND_EXPIRED;
                            res_task_next = rd_entry_reg.tid;
                            res_rem_next  = '0;
                            state_next    = S_RESP;
                        end
                        else
                        begin
                            rd_en  = 1'b1;
                            rd_idx = CNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.kind         = res_kind_reg;
                    rsp_next.task_id_out  = res_task_reg;
                    rsp_next.remaining_us = res_rem_reg;
                    rsp_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            base_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            tick_length_reg <= dlq_pkg::TICK_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            rsp_valid_reg <= rsp_valid_next;
            if (tick_length_we)
            begin
                tick_length_reg <= tick_length_us;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        task_reg      <= task_next;
        dur_reg       <= dur_next;
        sum_reg       <= sum_next;
        hit_delta_reg <= hit_delta_next;
        pend_task_reg <= pend_task_next;
        res_kind_reg  <= res_kind_next;
        res_task_reg  <= res_task_next;
        res_rem_reg   <= res_rem_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// File: rtl/dlq_checker.sv
// port-level checker for the delta-list timer queue, bound to the top level
`include "delta_list_sleep_timer_queue_assert.svh"

module dlq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input dlq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input dlq_pkg::rsp_t rsp
);

    `DLQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
    `DLQ_ASSERT_SAME(a_rem_zero, rsp_valid && (rsp.kind != dlq_pkg::KIND_CANCELLED), rsp.remaining_us == '0, "remaining time set on a non-cancel result")
    `DLQ_ASSERT_SAME(a_single_last, rsp_valid && (rsp.kind != dlq_pkg::KIND_EXPIRED), rsp.last, "single result without last mark")
    `DLQ_ASSERT_NEXT(a_insert_busy, req_valid && !req_stall && (req.cmd == dlq_pkg::CMD_INSERT), req_stall, "insert transfer did not make the queue busy")

endmodule

bind delta_list_sleep_timer_queue dlq_checker u_dlq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
